// ----- rtl/ms_pkg.sv -----
// ----------------------------------------------------------------------------
// Minimizer sketch package
// Shared types and constants for the minimizer sketch front end, queue and
// window engine.
// ----------------------------------------------------------------------------
package ms_pkg;

  localparam int KMER_MAX = 31;
  localparam int KMER_W   = 62;
  localparam int POS_W    = 31;
  localparam int LIMIT_W  = 34;

  // Configuration register indexes.
  localparam logic [2:0] REG_KMER_LENGTH    = 3'd0;
  localparam logic [2:0] REG_WINDOW_LENGTH  = 3'd1;
  localparam logic [2:0] REG_START_POSITION = 3'd2;
  localparam logic [2:0] REG_SEQUENCE_ID    = 3'd3;

  // One classified base as handed from the front end to the window engine.
  typedef struct packed {
    logic                     has_kmer;
    logic [KMER_W-1:0]        hash;
    logic [POS_W-1:0]         pos;
    logic                     strand;
    logic                     do_emit;
    logic [LIMIT_W-1:0]       limit;
    logic                     last;
  } item_t;

endpackage

// ----- rtl/ms_fifo.sv -----
// ----------------------------------------------------------------------------
// Minimizer sketch item queue
// Short register queue that decouples the front end from the window engine.
// ----------------------------------------------------------------------------
module ms_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ms_pkg::item_t  push_data,
  output logic           full,
  input  logic           pop,
  output ms_pkg::item_t  head,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ms_pkg::item_t      slots [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [AW:0]        count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

// ----- rtl/ms_front.sv -----
// ----------------------------------------------------------------------------
// Minimizer sketch front end
// Shifts bases into the forward and reverse-complement k-mer registers,
// picks the canonical k-mer, hashes it and queues the classified item.
// ----------------------------------------------------------------------------
module ms_front #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           base,
  input  logic                 last,
  input  logic [4:0]           kmer_length,
  input  logic [5:0]           window_length,
  input  logic [30:0]          start_position,
  output logic                 push,
  output ms_pkg::item_t        push_data,
  input  logic                 full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t      state;
  logic [61:0]  fwd;
  logic [61:0]  rev;
  logic [31:0]  cnt;
  logic [61:0]  key;
  logic [61:0]  mask;
  logic [2:0]   hstep;
  ms_pkg::item_t itm;

  logic [4:0]   k_eff;
  logic [6:0]   w_eff;
  logic [61:0]  mask_now;
  logic [61:0]  fwd_next;
  logic [61:0]  rev_next;
  logic         kmer_full;
  logic         emit_ok;
  logic [33:0]  kpos;
  logic [61:0]  key_next;

  // Clamp the lengths to their legal ranges.
  always_comb begin
    k_eff = (kmer_length == '0) ? 5'd1 : kmer_length;
    if (window_length == '0) begin
      w_eff = 7'd1;
    end else if ({1'b0, window_length} > 7'(WINDOW_MAX)) begin
      w_eff = 7'(WINDOW_MAX);
    end else begin
      w_eff = {1'b0, window_length};
    end
  end

  // Next k-mer registers and classification of the incoming base.
  always_comb begin
    mask_now  = {62{1'b1}} >> (6'd62 - {k_eff, 1'b0});
    fwd_next  = ((fwd << 2) | {60'b0, base}) & mask_now;
    rev_next  = ((rev >> 2) | ({60'b0, ~base} << ({k_eff, 1'b0} - 6'd2))) & mask_now;
    kmer_full = ({1'b0, cnt} >= {28'b0, k_eff} - 33'd1);
    emit_ok   = ({1'b0, cnt} >= {28'b0, k_eff} + {26'b0, w_eff} - 33'd2);
    kpos      = {3'b0, start_position} + {2'b0, cnt} - {29'b0, k_eff} + 34'd1;
  end

  // One step of the shift-add hash per cycle.
  always_comb begin
    case (hstep)
      3'd0:    key_next = ((~key) + (key << 21)) & mask;
      3'd1:    key_next = key ^ (key >> 24);
      3'd2:    key_next = (key + (key << 3) + (key << 8)) & mask;
      3'd3:    key_next = key ^ (key >> 14);
      3'd4:    key_next = (key + (key << 2) + (key << 4)) & mask;
      3'd5:    key_next = key ^ (key >> 28);
      3'd6:    key_next = (key + (key << 31)) & mask;
      default: key_next = key;
    endcase
  end

  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && !full;

  always_comb begin
    push_data      = itm;
    push_data.hash = key;
  end

  // Sequencer for one base: accept, hash when a k-mer is present, hand over.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      fwd   <= '0;
      rev   <= '0;
      cnt   <= '0;
      hstep <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            itm.has_kmer <= kmer_full && (fwd_next != rev_next);
            itm.strand   <= !(fwd_next < rev_next);
            itm.pos      <= (kpos > 34'h07FFFFFFF) ? 31'h7FFFFFFF : kpos[30:0];
            itm.do_emit  <= kmer_full && emit_ok;
            itm.limit    <= kpos - {27'b0, w_eff} + 34'd2;
            itm.last     <= last;
            itm.hash     <= '0;
            key          <= (fwd_next < rev_next) ? fwd_next : rev_next;
            mask         <= mask_now;
            hstep        <= '0;
            if (last) begin
              fwd <= '0;
              rev <= '0;
              cnt <= '0;
            end else begin
              fwd <= fwd_next;
              rev <= rev_next;
              cnt <= (cnt == 32'hFFFFFFFF) ? cnt : cnt + 32'd1;
            end
            state <= (kmer_full && (fwd_next != rev_next)) ? F_HASH : F_PUSH;
          end
        end
        F_HASH: begin
          key   <= key_next;
          hstep <= hstep + 3'd1;
          if (hstep == 3'd6) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ms_back.sv -----
// ----------------------------------------------------------------------------
// Minimizer sketch window engine
// Keeps the monotonic window queue, emits tied minimum entries and retires
// entries that fall out of the window.
// ----------------------------------------------------------------------------
module ms_back #(
  parameter int WINDOW_MAX = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  ms_pkg::item_t  head,
  input  logic           empty,
  output logic           pop,
  input  logic [31:0]    sequence_id,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [61:0]    hash_value,
  output logic [31:0]    seq_ident,
  output logic [30:0]    position,
  output logic           strand,
  output logic           last_of_run
);

  localparam int WM = WINDOW_MAX;
  localparam int IW = (WM > 1) ? $clog2(WM) : 1;

  typedef enum logic [2:0] {
    B_IDLE   = 3'b001,
    B_EMIT   = 3'b010,
    B_RETIRE = 3'b100
  } bstate_t;

  bstate_t        state;
  ms_pkg::item_t  itm;
  logic [61:0]    q_hash [WM];
  logic [30:0]    q_pos  [WM];
  logic           q_str  [WM];
  logic [WM-1:0]  q_emit;
  logic [WM-1:0]  vld;

  logic [WM-1:0]  le;
  logic [WM-1:0]  ins;
  logic [WM-1:0]  tie;
  logic [WM-1:0]  cand;
  logic           all_le;
  logic [IW-1:0]  sel;
  logic           retire_hit;
  logic           emit_now;

  // Compare every entry against the incoming hash and the front hash.
  always_comb begin
    for (int j = 0; j < WM; j++) begin
      le[j]   = vld[j] && (q_hash[j] <= head.hash);
      tie[j]  = vld[j] && (q_hash[j] == q_hash[0]);
      cand[j] = tie[j] && !q_emit[j];
    end
    ins[0] = !le[0];
    for (int j = 1; j < WM; j++) begin
      ins[j] = !le[j] && le[j-1];
    end
    all_le = &le;
    sel = '0;
    for (int j = WM - 1; j >= 0; j--) begin
      if (cand[j]) begin
        sel = IW'(j);
      end
    end
    retire_hit = vld[0] && ({3'b0, q_pos[0]} < itm.limit);
  end

  assign pop      = (state == B_IDLE) && !empty;
  assign emit_now = (state == B_EMIT) && (cand != '0) && (!out_valid || out_ready);

  // Queue storage: insert, overflow shift, emit marking and front retirement.
  always_ff @(posedge clk) begin
    if (pop && head.has_kmer) begin
      if (all_le) begin
        for (int j = 0; j < WM - 1; j++) begin
          q_hash[j] <= q_hash[j+1];
          q_pos[j]  <= q_pos[j+1];
          q_str[j]  <= q_str[j+1];
          q_emit[j] <= q_emit[j+1];
        end
        q_hash[WM-1] <= head.hash;
        q_pos[WM-1]  <= head.pos;
        q_str[WM-1]  <= head.strand;
        q_emit[WM-1] <= 1'b0;
      end else begin
        for (int j = 0; j < WM; j++) begin
          if (ins[j]) begin
            q_hash[j] <= head.hash;
            q_pos[j]  <= head.pos;
            q_str[j]  <= head.strand;
            q_emit[j] <= 1'b0;
          end
        end
      end
    end else if (emit_now) begin
      q_emit[sel] <= 1'b1;
    end else if (state == B_RETIRE && retire_hit) begin
      for (int j = 0; j < WM - 1; j++) begin
        q_hash[j] <= q_hash[j+1];
        q_pos[j]  <= q_pos[j+1];
        q_str[j]  <= q_str[j+1];
        q_emit[j] <= q_emit[j+1];
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit_now) begin
      hash_value  <= q_hash[sel];
      seq_ident   <= sequence_id;
      position    <= q_pos[sel];
      strand      <= q_str[sel];
      last_of_run <= $onehot(cand);
    end
  end

  // Control: fill vector, sequencing and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Output valid rises with a new minimizer and falls after its transfer.
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            itm <= head;
            if (head.last && !head.do_emit) begin
              vld <= '0;
            end else if (head.has_kmer && !all_le) begin
              vld <= le | ins;
            end
            if (head.do_emit) begin
              state <= B_EMIT;
            end
          end
        end
        B_EMIT: begin
          if (cand == '0) begin
            state <= B_RETIRE;
          end
        end
        B_RETIRE: begin
          if (retire_hit) begin
            vld <= vld >> 1;
          end else begin
            if (itm.last) begin
              vld <= '0;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/minimizer_sketch.sv -----
// ----------------------------------------------------------------------------
// Minimizer sketch
// Streams 2-bit bases and emits (w,k) window minimizers of the canonical
// k-mers, with sequence identifier, start position and strand.
// ----------------------------------------------------------------------------
// Usage: bases enter on the in channel (base, last) with valid/ready; each
// minimizer leaves on the out channel with valid/ready, one per transfer.
// last_of_run marks the final minimizer caused by one base; last marks the
// final base of a sequence and clears k-mer and window state after it.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// The front end hands over a base without a hashable k-mer directly and
// one with a k-mer after the seven-step hash, run one step a cycle. The
// window engine inserts each item with a k-mer, then emits each minimizer
// in turn and retires each entry that falls out of the window; the
// four-deep queue between the two lets the front end run ahead. The first
// minimizer of a base passes from the queue through the engine's emit
// state into the output register. A stalled receiver holds the output
// register and the engine waits; the front end keeps accepting until the
// queue fills. Reset clears all control state and restores the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module minimizer_sketch #(
  parameter int WINDOW_MAX = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   base,
  input  logic         last,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [61:0]  hash_value,
  output logic [31:0]  seq_ident,
  output logic [30:0]  position,
  output logic         strand,
  output logic         last_of_run,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [4:0]    kmer_length;
  logic [5:0]    window_length;
  logic [30:0]   start_position;
  logic [31:0]   sequence_id;

  logic          fifo_push;
  logic          fifo_full;
  logic          fifo_pop;
  logic          fifo_empty;
  ms_pkg::item_t fifo_in;
  ms_pkg::item_t fifo_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length    <= 5'd15;
      window_length  <= 6'd5;
      start_position <= '0;
      sequence_id    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ms_pkg::REG_KMER_LENGTH:    kmer_length    <= cfg_data[4:0];
        ms_pkg::REG_WINDOW_LENGTH:  window_length  <= cfg_data[5:0];
        ms_pkg::REG_START_POSITION: start_position <= cfg_data[30:0];
        ms_pkg::REG_SEQUENCE_ID:    sequence_id    <= cfg_data;
        default: ;
      endcase
    end
  end

  ms_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .base           (base),
    .last           (last),
    .kmer_length    (kmer_length),
    .window_length  (window_length),
    .start_position (start_position),
    .push           (fifo_push),
    .push_data      (fifo_in),
    .full           (fifo_full)
  );

  ms_fifo #(.DEPTH(4)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (fifo_in),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .head      (fifo_head),
    .empty     (fifo_empty)
  );

  ms_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (fifo_head),
    .empty       (fifo_empty),
    .pop         (fifo_pop),
    .sequence_id (sequence_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hash_value  (hash_value),
    .seq_ident   (seq_ident),
    .position    (position),
    .strand      (strand),
    .last_of_run (last_of_run)
  );

`ifndef NO_ASSERTIONS
  // A transfer makes the front end busy, so it never takes two bases back to back.
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("front end took two bases back to back");

  // The front end never hands over into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(fifo_push && fifo_full)) else $error("queue overflow");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output valid after reset");
`endif

endmodule
